// File: src/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int COUNT_BITS_DEFAULT = 24;

  localparam int HDR_BYTES       = 16;
  localparam int FRAME_SIZE_BITS = 32;
  localparam int MAX_FRAME_BITS  = 24;

  localparam logic [31:0] OP_POPULARITY = 32'd3;
  localparam logic [31:0] OP_COMMAND    = 32'd5;

  localparam logic [MAX_FRAME_BITS-1:0] MAX_FRAME_RESET = 24'd10485760;

  // configuration register indexes
  localparam int          CFG_INDEX_BITS = 1;
  localparam int          CFG_DATA_BITS  = 24;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_FRAME = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_READING   = 1'd1;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [31:0] frame_op;
    logic [15:0] frame_version;
    logic        last_of_frame;
    logic [31:0] popularity;
    logic        popularity_valid;
    logic        frame_error;
  } res_t;

endpackage

// File: src/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Splits a received byte stream into frames with a 16-byte big-endian header,
// checks the frame size and extracts command payload and counter values.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while in_stall is low and returns one result
// per byte. Each result is registered into the output register (or the skid
// register if that is stalled) together with the byte counter and header
// fields, so the next byte can follow immediately. A two-entry output stage
// (output register plus skid register) takes one more byte after the output
// side stalls; in_stall rises only when both entries are full.
module length_prefixed_frame_deframer #(
  parameter int COUNT_BITS = lpfd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [lpfd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lpfd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          data_byte,
  input  logic                                restart,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          payload_byte,
  output logic                                payload_valid,
  output logic [31:0]                         frame_op,
  output logic [15:0]                         frame_version,
  output logic                                last_of_frame,
  output logic [31:0]                         popularity,
  output logic                                popularity_valid,
  output logic                                frame_error
);

  localparam int HDR = lpfd_pkg::HDR_BYTES;

  // configuration registers
  logic [lpfd_pkg::MAX_FRAME_BITS-1:0] max_frame_bytes;
  logic                                reading_enabled;

  // frame state
  logic [COUNT_BITS-1:0] byte_count;
  logic [31:0]           frame_size;
  logic [15:0]           declared_header_size;
  logic [15:0]           version_reg;
  logic [31:0]           op_reg;
  logic [31:0]           counter_accumulator;

  logic [COUNT_BITS-1:0] byte_count_next;
  logic [31:0]           frame_size_next;
  logic [15:0]           declared_header_size_next;
  logic [15:0]           version_reg_next;
  logic [31:0]           op_reg_next;
  logic [31:0]           counter_accumulator_next;

  // output stage
  lpfd_pkg::res_t res_next;
  lpfd_pkg::res_t main_res;
  lpfd_pkg::res_t skid_res;
  logic           main_valid;
  logic           skid_valid;

  logic in_xfer;
  logic out_xfer;

  logic [COUNT_BITS-1:0] pos;
  logic [COUNT_BITS-1:0] body_idx;
  logic [32:0]           size_m1;
  logic                  size_over_count;
  logic [32:0]           pos_plus1;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = main_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= lpfd_pkg::MAX_FRAME_RESET;
      reading_enabled <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        lpfd_pkg::CFG_MAX_FRAME: max_frame_bytes <= cfg_data[lpfd_pkg::MAX_FRAME_BITS-1:0];
        lpfd_pkg::CFG_READING:   reading_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign pos       = restart ? '0 : byte_count;
  assign body_idx  = pos - COUNT_BITS'(HDR);
  assign pos_plus1 = 33'(pos) + 33'd1;
  assign size_m1   = {1'b0, frame_size} - 33'd1;
  // size-1 beyond what the counter can hold
  assign size_over_count = (size_m1 >> COUNT_BITS) != 33'd0;

  always_comb begin
    byte_count_next           = byte_count;
    frame_size_next           = frame_size;
    declared_header_size_next = declared_header_size;
    version_reg_next          = version_reg;
    op_reg_next               = op_reg;
    counter_accumulator_next  = counter_accumulator;
    res_next                  = '0;

    if (pos < COUNT_BITS'(HDR)) begin
      if (pos < COUNT_BITS'(4)) begin
        frame_size_next = {frame_size[23:0], data_byte};
      end else if (pos < COUNT_BITS'(6)) begin
        declared_header_size_next = {declared_header_size[7:0], data_byte};
      end else if (pos < COUNT_BITS'(8)) begin
        version_reg_next = {version_reg[7:0], data_byte};
      end else if (pos < COUNT_BITS'(12)) begin
        op_reg_next = {op_reg[23:0], data_byte};
      end

      if (pos == COUNT_BITS'(HDR - 1)) begin
        counter_accumulator_next = '0;
        if (frame_size < 32'(HDR) || frame_size >= 32'(max_frame_bytes) ||
            size_over_count) begin
          res_next.frame_error = 1'b1;
          byte_count_next      = '0;
        end else if (frame_size == 32'(HDR)) begin
          res_next.last_of_frame = 1'b1;
          byte_count_next        = '0;
        end else begin
          byte_count_next = COUNT_BITS'(HDR);
        end
      end else begin
        byte_count_next = pos + COUNT_BITS'(1);
      end
    end else begin
      if (op_reg == lpfd_pkg::OP_POPULARITY && body_idx < COUNT_BITS'(4)) begin
        counter_accumulator_next = {counter_accumulator[23:0], data_byte};
        if (body_idx == COUNT_BITS'(3)) begin
          res_next.popularity       = {counter_accumulator[23:0], data_byte};
          res_next.popularity_valid = 1'b1;
        end
      end else if (op_reg == lpfd_pkg::OP_COMMAND && reading_enabled) begin
        res_next.payload_byte  = data_byte;
        res_next.payload_valid = 1'b1;
      end
      if (pos_plus1 >= {1'b0, frame_size}) begin
        res_next.last_of_frame = 1'b1;
        byte_count_next        = '0;
      end else begin
        // wraps at the counter width
        byte_count_next = pos_plus1[COUNT_BITS-1:0];
      end
    end

    res_next.frame_op      = op_reg_next;
    res_next.frame_version = version_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count           <= '0;
      frame_size           <= '0;
      declared_header_size <= '0;
      version_reg          <= '0;
      op_reg               <= '0;
      counter_accumulator  <= '0;
    end else if (in_xfer) begin
      byte_count           <= byte_count_next;
      frame_size           <= frame_size_next;
      declared_header_size <= declared_header_size_next;
      version_reg          <= version_reg_next;
      op_reg               <= op_reg_next;
      counter_accumulator  <= counter_accumulator_next;
    end
  end

  // two-entry output stage: park a new result in skid while main is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_xfer) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (in_xfer) begin
        if (main_valid && !out_xfer) begin
          skid_valid <= 1'b1;
        end else begin
          main_valid <= 1'b1;
        end
      end else if (out_xfer) begin
        main_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        main_res <= skid_res;
      end
    end else if (in_xfer) begin
      if (main_valid && !out_xfer) begin
        skid_res <= res_next;
      end else begin
        main_res <= res_next;
      end
    end
  end

  assign out_valid        = main_valid;
  assign payload_byte     = main_res.payload_byte;
  assign payload_valid    = main_res.payload_valid;
  assign frame_op         = main_res.frame_op;
  assign frame_version    = main_res.frame_version;
  assign last_of_frame    = main_res.last_of_frame;
  assign popularity       = main_res.popularity;
  assign popularity_valid = main_res.popularity_valid;
  assign frame_error      = main_res.frame_error;

`ifndef NO_ASSERTIONS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held while output register is empty");

  a_skid_drains_first: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_xfer) |=> (main_valid && !skid_valid))
    else $error("skid entry not moved to output register");

  a_error_not_last: assert property (@(posedge clk) disable iff (rst)
    main_valid |-> !(frame_error && last_of_frame))
    else $error("rejected frame marked as complete");

  a_one_body_kind: assert property (@(posedge clk) disable iff (rst)
    main_valid |-> !(payload_valid && popularity_valid))
    else $error("payload and counter delivered for the same byte");

  a_restart_count: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && restart) |=> (byte_count == COUNT_BITS'(1)))
    else $error("restart did not realign the byte counter");
`endif

endmodule

// File: dv/length_prefixed_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_tb
// Self-checking bench for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
// Bytes are built into frames (header-only, bad sizes, counter and command
// bodies, cut frames, restarts and noise), pushed through the input channel
// with random gaps and predicted one result per byte. The output channel
// stalls at random, and each output transfer is compared field by field
// with the oldest prediction. Several register settings are run, including
// the extremes of the size limit and both reading modes.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              WATCHDOG_CYCLES = 2000;
  localparam int              CNT_BITS        = lpfd_pkg::COUNT_BITS_DEFAULT;
  localparam longint unsigned POS_LIMIT       = (64'd1 << CNT_BITS) - 1;

  class deframe_scoreboard;
    logic [lpfd_pkg::MAX_FRAME_BITS-1:0] max_frame;
    bit                                  reading_on;
    bit [CNT_BITS-1:0]                   byte_pos;
    bit [31:0]                           size_field;
    bit [15:0]                           hdr_len_field;
    bit [15:0]                           version_field;
    bit [31:0]                           op_field;
    bit [31:0]                           counter_acc;
    lpfd_pkg::res_t                      pending_results[$];
    int                                  errors;
    int                                  results_seen;

    function new();
      max_frame     = lpfd_pkg::MAX_FRAME_RESET;
      reading_on    = 1'b1;
      byte_pos      = '0;
      size_field    = '0;
      hdr_len_field = '0;
      version_field = '0;
      op_field      = '0;
      counter_acc   = '0;
      errors        = 0;
      results_seen  = 0;
    endfunction

    function void write_reg(logic [lpfd_pkg::CFG_INDEX_BITS-1:0] idx,
                            logic [lpfd_pkg::CFG_DATA_BITS-1:0] val);
      if (idx == lpfd_pkg::CFG_MAX_FRAME) begin
        max_frame = val;
      end else if (idx == lpfd_pkg::CFG_READING) begin
        reading_on = val[0];
      end
    endfunction

    // Work out the result of one accepted byte and queue it.
    function void predict_byte(bit [7:0] b, bit rs);
      lpfd_pkg::res_t  r;
      longint unsigned pos;
      longint unsigned body_idx;
      r = '0;
      if (rs) byte_pos = '0;
      pos = 64'(byte_pos);
      if (pos < lpfd_pkg::HDR_BYTES) begin
        if (pos < 4) size_field = {size_field[23:0], b};
        else if (pos < 6) hdr_len_field = {hdr_len_field[7:0], b};
        else if (pos < 8) version_field = {version_field[7:0], b};
        else if (pos < 12) op_field = {op_field[23:0], b};
        if (pos == lpfd_pkg::HDR_BYTES - 1) begin
          counter_acc = '0;
          if (size_field < lpfd_pkg::HDR_BYTES || size_field >= max_frame ||
              longint'(size_field) - 1 > POS_LIMIT) begin
            r.frame_error = 1'b1;
            byte_pos = '0;
          end else if (size_field == lpfd_pkg::HDR_BYTES) begin
            r.last_of_frame = 1'b1;
            byte_pos = '0;
          end else begin
            byte_pos = CNT_BITS'(lpfd_pkg::HDR_BYTES);
          end
        end else begin
          byte_pos = CNT_BITS'(pos + 1);
        end
      end else begin
        body_idx = pos - lpfd_pkg::HDR_BYTES;
        if (op_field == lpfd_pkg::OP_POPULARITY && body_idx < 4) begin
          counter_acc = {counter_acc[23:0], b};
          if (body_idx == 3) begin
            r.popularity       = counter_acc;
            r.popularity_valid = 1'b1;
          end
        end else if (op_field == lpfd_pkg::OP_COMMAND && reading_on) begin
          r.payload_byte  = b;
          r.payload_valid = 1'b1;
        end
        if (pos + 1 >= longint'(size_field)) begin
          r.last_of_frame = 1'b1;
          byte_pos = '0;
        end else begin
          byte_pos = CNT_BITS'(pos + 1);
        end
      end
      r.frame_op      = op_field;
      r.frame_version = version_field;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", results_seen, name, got, want));
    endtask

    task check_result(lpfd_pkg::res_t got);
      lpfd_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with no byte outstanding", results_seen));
        results_seen++;
        return;
      end
      want = pending_results.pop_front();
      cmp("payload_byte", got.payload_byte, want.payload_byte);
      cmp("payload_valid", got.payload_valid, want.payload_valid);
      cmp("frame_op", got.frame_op, want.frame_op);
      cmp("frame_version", got.frame_version, want.frame_version);
      cmp("last_of_frame", got.last_of_frame, want.last_of_frame);
      cmp("popularity", got.popularity, want.popularity);
      cmp("popularity_valid", got.popularity_valid, want.popularity_valid);
      cmp("frame_error", got.frame_error, want.frame_error);
      results_seen++;
    endtask
  endclass

  typedef struct {
    bit [7:0] value;
    bit       restart;
  } link_byte_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_we;
  logic [lpfd_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [lpfd_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic [7:0]                          data_byte;
  logic                                restart;
  logic                                out_valid;
  logic                                out_stall;
  logic [7:0]                          payload_byte;
  logic                                payload_valid;
  logic [31:0]                         frame_op;
  logic [15:0]                         frame_version;
  logic                                last_of_frame;
  logic [31:0]                         popularity;
  logic                                popularity_valid;
  logic                                frame_error;

  deframe_scoreboard sb;
  link_byte_t        link_q[$];
  bit                resync_needed;
  int                gap_pct;
  int                stall_pct;
  int                stall_left;
  int                quiet_cycles;

  length_prefixed_frame_deframer dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .restart          (restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .payload_byte     (payload_byte),
    .payload_valid    (payload_valid),
    .frame_op         (frame_op),
    .frame_version    (frame_version),
    .last_of_frame    (last_of_frame),
    .popularity       (popularity),
    .popularity_valid (popularity_valid),
    .frame_error      (frame_error)
  );

  always #6 clk = ~clk;

  // Mostly short idle runs, now and then a long one.
  function automatic int idle_len(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(6) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  always @(negedge clk) begin
    if (stall_left == 0) stall_left = idle_len(stall_pct);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    lpfd_pkg::res_t got;
    if (!rst && out_valid && !out_stall) begin
      got.payload_byte     = payload_byte;
      got.payload_valid    = payload_valid;
      got.frame_op         = frame_op;
      got.frame_version    = frame_version;
      got.last_of_frame    = last_of_frame;
      got.popularity       = popularity;
      got.popularity_valid = popularity_valid;
      got.frame_error      = frame_error;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("length_prefixed_frame_deframer verification failed");
      $finish;
    end
  end

  task write_reg(logic [lpfd_pkg::CFG_INDEX_BITS-1:0] idx,
                 logic [lpfd_pkg::CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Queue one frame. fill < 0 gives random body bytes; limit >= 0 cuts the
  // frame after that many bytes. Rejected sizes get no body.
  task push_frame(bit [31:0] size, bit [15:0] ver, bit [31:0] op, bit rs,
                  int limit, int fill);
    bit [7:0]        hdr[16];
    longint unsigned total;
    longint unsigned n;
    link_byte_t      lb;
    bit [31:0]       seq;
    bit [15:0]       hlen;
    seq  = $urandom;
    hlen = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(lpfd_pkg::HDR_BYTES);
    {hdr[0], hdr[1], hdr[2], hdr[3]}     = size;
    {hdr[4], hdr[5]}                     = hlen;
    {hdr[6], hdr[7]}                     = ver;
    {hdr[8], hdr[9], hdr[10], hdr[11]}   = op;
    {hdr[12], hdr[13], hdr[14], hdr[15]} = seq;
    total = lpfd_pkg::HDR_BYTES;
    if (size >= lpfd_pkg::HDR_BYTES && size < sb.max_frame) total = size;
    if (limit >= 0 && limit < total) total = limit;
    for (n = 0; n < total; n++) begin
      if (n < lpfd_pkg::HDR_BYTES) lb.value = hdr[n];
      else lb.value = (fill < 0) ? 8'($urandom) : 8'(fill);
      lb.restart = (n == 0) ? rs : 1'b0;
      link_q.push_back(lb);
    end
  endtask

  task push_random_frame();
    int        kind;
    int        pick;
    int        n;
    bit [31:0] size;
    bit [31:0] op;
    bit [15:0] ver;
    bit        rs;
    int        limit;
    link_byte_t lb;
    kind  = $urandom_range(99);
    rs    = resync_needed || ($urandom_range(9) == 0);
    limit = -1;
    if (kind >= 93) begin
      // noise: loose bytes with stray restarts
      n = $urandom_range(1, 12);
      repeat (n) begin
        lb.value   = 8'($urandom);
        lb.restart = ($urandom_range(3) == 0);
        link_q.push_back(lb);
      end
      resync_needed = 1'b1;
      return;
    end
    if ($urandom_range(19) == 0) size = lpfd_pkg::HDR_BYTES + $urandom_range(40, 160);
    else size = lpfd_pkg::HDR_BYTES + $urandom_range(0, 24);
    if (kind >= 75 && kind < 85) begin
      pick = $urandom_range(3);
      case (pick)
        0:       size = $urandom_range(0, lpfd_pkg::HDR_BYTES - 1);
        1:       size = {8'($urandom_range(1, 255)), 24'($urandom)};
        2:       size = 32'(sb.max_frame) + $urandom_range(0, 3);
        default: size = 32'hFFFF_FFFF;
      endcase
      if (size >= lpfd_pkg::HDR_BYTES && size < sb.max_frame) size = 32'hFFFF_FFFF;
    end
    pick = $urandom_range(9);
    if (pick < 4) op = lpfd_pkg::OP_POPULARITY;
    else if (pick < 8) op = lpfd_pkg::OP_COMMAND;
    else if (pick == 8) op = $urandom_range(7);
    else op = $urandom;
    pick = $urandom_range(3);
    case (pick)
      0:       ver = 16'd0;
      1:       ver = 16'd2;
      2:       ver = 16'd3;
      default: ver = 16'($urandom);
    endcase
    if (kind >= 85) limit = int'($urandom_range(1, size - 1));
    push_frame(size, ver, op, rs, limit, -1);
    resync_needed = (kind >= 85);
  endtask

  task send_byte(link_byte_t lb);
    int gap;
    gap = idle_len(gap_pct);
    @(negedge clk);
    while (gap > 0) begin
      in_valid <= 1'b0;
      @(negedge clk);
      gap--;
    end
    in_valid  <= 1'b1;
    data_byte <= lb.value;
    restart   <= lb.restart;
    do @(posedge clk); while (in_stall);
    sb.predict_byte(lb.value, lb.restart);
  endtask

  task drive_link();
    while (link_q.size() > 0) send_byte(link_q.pop_front());
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task run_phase(logic [lpfd_pkg::CFG_DATA_BITS-1:0] max_bytes, bit reading, int gaps,
                 int stalls, int n_bytes);
    write_reg(lpfd_pkg::CFG_MAX_FRAME, max_bytes);
    write_reg(lpfd_pkg::CFG_READING, {23'($urandom), reading});
    gap_pct       = gaps;
    stall_pct     = stalls;
    resync_needed = 1'b1;
    while (link_q.size() < n_bytes) push_random_frame();
    drive_link();
    drain();
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    data_byte    = '0;
    restart      = 1'b0;
    out_stall    = 1'b0;
    stall_left   = 0;
    quiet_cycles = 0;
    gap_pct      = 20;
    stall_pct    = 20;
    sb           = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames at the reset settings
    push_frame(lpfd_pkg::HDR_BYTES, 16'd0, lpfd_pkg::OP_COMMAND, 1'b0, -1, -1);
    push_frame(15, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, -1, -1);
    push_frame(0, 16'd2, 32'd0, 1'b0, -1, -1);
    push_frame(32'hFFFF_FFFF, 16'd2, lpfd_pkg::OP_POPULARITY, 1'b0, -1, -1);
    push_frame(lpfd_pkg::MAX_FRAME_RESET, 16'd3, lpfd_pkg::OP_COMMAND, 1'b0, -1, -1);
    push_frame(20, 16'd0, lpfd_pkg::OP_POPULARITY, 1'b0, -1, 8'hFF);
    push_frame(21, 16'd0, lpfd_pkg::OP_POPULARITY, 1'b0, -1, 8'h00);
    push_frame(18, 16'd0, lpfd_pkg::OP_POPULARITY, 1'b0, -1, -1);
    push_frame(17, 16'd0, lpfd_pkg::OP_COMMAND, 1'b0, -1, 8'hFF);
    push_frame(18, 16'd2, lpfd_pkg::OP_COMMAND, 1'b0, -1, 8'h00);
    push_frame(20, 16'hFFFF, 32'h8000_0000, 1'b0, -1, -1);
    // cut header, then a resync by restart
    push_frame(19, 16'd0, lpfd_pkg::OP_COMMAND, 1'b0, 7, -1);
    push_frame(19, 16'd3, lpfd_pkg::OP_COMMAND, 1'b1, -1, -1);
    // largest accepted size: take a few body bytes, then abandon it
    push_frame(lpfd_pkg::MAX_FRAME_RESET - 1, 16'd0, lpfd_pkg::OP_COMMAND, 1'b0, 20, -1);
    push_frame(lpfd_pkg::HDR_BYTES, 16'd0, lpfd_pkg::OP_POPULARITY, 1'b1, -1, -1);
    drive_link();
    drain();

    run_phase(24'd17, 1'b1, 30, 30, 110);
    run_phase(24'hFFFFFF, 1'b0, 10, 50, 190);
    run_phase(24'd16, 1'b1, 25, 5, 60);
    run_phase(24'($urandom_range(17, 300)), 1'($urandom), 20, 20, 220);
    run_phase(24'd40, 1'b1, 0, 0, 180);
    run_phase(24'd0, 1'b0, 20, 20, 40);

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
    if (sb.errors == 0) begin
      $display("length_prefixed_frame_deframer verification clean");
    end else begin
      $display("length_prefixed_frame_deframer verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/lpfd_pkg.sv
src/length_prefixed_frame_deframer.sv
dv/length_prefixed_frame_deframer_tb.sv
